[rtl/core/round_robin_thread_scheduler_unit_macros.svh]
// ----------------------------------------------------------------------------
// Round-robin thread scheduler assertion macros
// Shared concurrent assertion forms used by the scheduler RTL.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_THREAD_SCHEDULER_UNIT_MACROS_SVH
`define ROUND_ROBIN_THREAD_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RRTS_ASSERT_IMP(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, checked outside reset.
`define RRTS_ASSERT_NXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

[rtl/core/rrts_pkg.sv]
// ----------------------------------------------------------------------------
// Round-robin thread scheduler package
// Event kinds, status codes, thread states and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package rrts_pkg;

  typedef enum logic [2:0] {
    KIND_CREATE = 3'd0,
    KIND_TICK   = 3'd1,
    KIND_YIELD  = 3'd2,
    KIND_BLOCK  = 3'd3,
    KIND_WAKE   = 3'd4,
    KIND_TERM   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_REFUSED = 2'd2,
    STAT_NOTBLK  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    THR_UNUSED  = 3'd0,
    THR_READY   = 3'd1,
    THR_RUNNING = 3'd2,
    THR_BLOCKED = 3'd3,
    THR_TERM    = 3'd4
  } thr_state_e;

  typedef enum logic [5:0] {
    FSM_IDLE   = 6'b000001,
    FSM_FIRST  = 6'b000010,
    FSM_WALK   = 6'b000100,
    FSM_SW_OLD = 6'b001000,
    FSM_SW_NEW = 6'b010000,
    FSM_CRE2   = 6'b100000
  } fsm_e;

  function automatic logic is_runnable(thr_state_e st);
    return (st == THR_READY) || (st == THR_RUNNING);
  endfunction

endpackage

`default_nettype wire

[rtl/core/round_robin_thread_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// Round-robin thread scheduler
// Thread records and switch counters live in two RAMs; a sequencer walks the
// ring one link per cycle and writes updated records back.
//
// Channel   Direction  Handshake            Payload
// event     in         start_i / busy_o     kind_i, target_i
// result    out        done_o (one cycle)   status_o, current_id_o, switched_o,
//                                           new_id_o, switch_count_o,
//                                           tick_total_o
//
// A beat is taken when start_i is high and busy_o is low; busy_o rises on the
// next cycle. Create checks the fill count in FSM_FIRST and, unless the table
// is full, writes the new record there and relinks slot 0 in FSM_CRE2; wake
// and terminate finish in FSM_FIRST. A tick, yield or block walks the ring in
// FSM_WALK, reading one record at a time through the single read port of the
// record RAM, and on a switch writes the old and new records in FSM_SW_OLD and
// FSM_SW_NEW. done_o is high in the first cycle with busy_o low, and a new
// event may be taken in that same cycle. The receiver cannot stall results.
// Reset puts idle thread 0 running alone in the ring; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "round_robin_thread_scheduler_unit_macros.svh"

module round_robin_thread_scheduler_unit #(
  parameter int MAX_THREADS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [3:0]  target_i,
  output logic             done_o,
  output logic [1:0]       status_o,
  output logic [3:0]       current_id_o,
  output logic             switched_o,
  output logic [3:0]       new_id_o,
  output logic [31:0]      switch_count_o,
  output logic [31:0]      tick_total_o
);

  localparam int IW = $clog2(MAX_THREADS);
  localparam int CW = IW + 1;

  typedef struct packed {
    rrts_pkg::thr_state_e st;
    logic [IW-1:0]        link;
  } rec_t;

  localparam int RW = $bits(rec_t);

  // Control state.
  rrts_pkg::fsm_e state_q, state_d;
  logic [IW-1:0]  cur_q, cur_d;
  logic [CW-1:0]  nfree_q, nfree_d;
  logic [31:0]    tick_q, tick_d;
  logic [31:0]    cur_cnt_q, cur_cnt_d;
  logic           rec0_ok_q, cnt0_ok_q;
  logic           done_q, done_d;

  // Per-event working registers.
  logic [2:0]     kind_q, kind_d;
  logic [3:0]     tgt_q, tgt_d;
  logic [IW-1:0]  cand_q, cand_d;
  rec_t           old_rec_q, old_rec_d;
  rec_t           nxt_rec_q, nxt_rec_d;
  logic [IW-1:0]  rec_raddr_q, cnt_raddr_q;
  logic [1:0]     status_q, status_d;
  logic           switched_q, switched_d;
  logic [IW-1:0]  new_id_q, new_id_d;

  // RAM ports.
  logic           rec_we, rec_re, cnt_we, cnt_re;
  logic [IW-1:0]  rec_waddr, rec_raddr, cnt_waddr, cnt_raddr;
  rec_t           rec_wdata;
  logic [RW-1:0]  rec_rdata;
  logic [31:0]    cnt_wdata, cnt_rdata;

  rec_t           rec_eff;
  logic [31:0]    cnt_eff;
  logic [31:0]    cnt_inc;
  logic           target_ok;

  rrts_ram #(.WIDTH(RW), .DEPTH(MAX_THREADS)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .re_i    (rec_re),
    .raddr_i (rec_raddr),
    .rdata_o (rec_rdata)
  );

  rrts_ram #(.WIDTH(32), .DEPTH(MAX_THREADS)) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cnt_re),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  // Slot 0 holds its reset contents until first written, and ids at or past
  // the fill count have never been created, so they read as unused.
  always_comb begin
    rec_eff = rec_t'(rec_rdata);
    if (rec_raddr_q == '0 && !rec0_ok_q) begin
      rec_eff = '{st: rrts_pkg::THR_RUNNING, link: '0};
    end else if ({1'b0, rec_raddr_q} >= nfree_q) begin
      rec_eff = '{st: rrts_pkg::THR_UNUSED, link: '0};
    end
  end

  assign cnt_eff   = (cnt_raddr_q == '0 && !cnt0_ok_q) ? 32'd0 : cnt_rdata;
  assign cnt_inc   = cnt_eff + 32'd1;
  assign target_ok = ({28'd0, tgt_q} < 32'(MAX_THREADS));

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    nfree_d    = nfree_q;
    tick_d     = tick_q;
    cur_cnt_d  = cur_cnt_q;
    done_d     = 1'b0;
    kind_d     = kind_q;
    tgt_d      = tgt_q;
    cand_d     = cand_q;
    old_rec_d  = old_rec_q;
    nxt_rec_d  = nxt_rec_q;
    status_d   = status_q;
    switched_d = switched_q;
    new_id_d   = new_id_q;
    rec_we     = 1'b0;
    rec_waddr  = cur_q;
    rec_wdata  = old_rec_q;
    rec_re     = 1'b0;
    rec_raddr  = cur_q;
    cnt_we     = 1'b0;
    cnt_waddr  = cand_q;
    cnt_wdata  = cnt_inc;
    cnt_re     = 1'b0;
    cnt_raddr  = cand_q;

    case (state_q)
      rrts_pkg::FSM_IDLE: begin
        if (start_i) begin
          kind_d     = kind_i;
          tgt_d      = target_i;
          status_d   = rrts_pkg::STAT_OK;
          switched_d = 1'b0;
          new_id_d   = '0;
          rec_re     = 1'b1;
          case (kind_i)
            rrts_pkg::KIND_CREATE: rec_raddr = '0;
            rrts_pkg::KIND_WAKE:   rec_raddr = IW'(target_i);
            default:               rec_raddr = cur_q;
          endcase
          if (kind_i == rrts_pkg::KIND_TICK) begin
            tick_d = tick_q + 32'd1;
          end
          state_d = rrts_pkg::FSM_FIRST;
        end
      end

      rrts_pkg::FSM_FIRST: begin
        old_rec_d = rec_eff;
        case (kind_q)
          rrts_pkg::KIND_CREATE: begin
            if (nfree_q >= CW'(MAX_THREADS)) begin
              status_d = rrts_pkg::STAT_FULL;
              done_d   = 1'b1;
              state_d  = rrts_pkg::FSM_IDLE;
            end else begin
              // New thread takes over slot 0's old successor.
              rec_we    = 1'b1;
              rec_waddr = nfree_q[IW-1:0];
              rec_wdata = '{st: rrts_pkg::THR_READY, link: rec_eff.link};
              cnt_we    = 1'b1;
              cnt_waddr = nfree_q[IW-1:0];
              cnt_wdata = 32'd0;
              state_d   = rrts_pkg::FSM_CRE2;
            end
          end
          rrts_pkg::KIND_WAKE: begin
            if (target_ok && rec_eff.st == rrts_pkg::THR_BLOCKED) begin
              rec_we    = 1'b1;
              rec_waddr = rec_raddr_q;
              rec_wdata = '{st: rrts_pkg::THR_READY, link: rec_eff.link};
            end else begin
              status_d = rrts_pkg::STAT_NOTBLK;
            end
            done_d  = 1'b1;
            state_d = rrts_pkg::FSM_IDLE;
          end
          rrts_pkg::KIND_TERM: begin
            rec_we    = 1'b1;
            rec_waddr = cur_q;
            rec_wdata = '{st: rrts_pkg::THR_TERM, link: rec_eff.link};
            done_d    = 1'b1;
            state_d   = rrts_pkg::FSM_IDLE;
          end
          rrts_pkg::KIND_TICK, rrts_pkg::KIND_YIELD, rrts_pkg::KIND_BLOCK: begin
            if (rec_eff.link == cur_q) begin
              if (kind_q == rrts_pkg::KIND_BLOCK) begin
                status_d = rrts_pkg::STAT_REFUSED;
              end
              done_d  = 1'b1;
              state_d = rrts_pkg::FSM_IDLE;
            end else begin
              rec_re    = 1'b1;
              rec_raddr = rec_eff.link;
              state_d   = rrts_pkg::FSM_WALK;
            end
          end
          default: begin
            done_d  = 1'b1;
            state_d = rrts_pkg::FSM_IDLE;
          end
        endcase
      end

      rrts_pkg::FSM_WALK: begin
        if (rrts_pkg::is_runnable(rec_eff.st)) begin
          nxt_rec_d = rec_eff;
          cand_d    = rec_raddr_q;
          cnt_re    = 1'b1;
          cnt_raddr = rec_raddr_q;
          state_d   = rrts_pkg::FSM_SW_OLD;
        end else if (rec_eff.link == cur_q) begin
          // Went all the way round without finding another runnable thread.
          if (kind_q == rrts_pkg::KIND_BLOCK) begin
            status_d = rrts_pkg::STAT_REFUSED;
          end
          done_d  = 1'b1;
          state_d = rrts_pkg::FSM_IDLE;
        end else begin
          rec_re    = 1'b1;
          rec_raddr = rec_eff.link;
        end
      end

      rrts_pkg::FSM_SW_OLD: begin
        rec_we    = 1'b1;
        rec_waddr = cur_q;
        rec_wdata = old_rec_q;
        if (kind_q == rrts_pkg::KIND_BLOCK) begin
          rec_wdata.st = rrts_pkg::THR_BLOCKED;
        end else if (old_rec_q.st == rrts_pkg::THR_RUNNING) begin
          rec_wdata.st = rrts_pkg::THR_READY;
        end
        cnt_we    = 1'b1;
        cnt_waddr = cand_q;
        cnt_wdata = cnt_inc;
        cur_cnt_d = cnt_inc;
        state_d   = rrts_pkg::FSM_SW_NEW;
      end

      rrts_pkg::FSM_SW_NEW: begin
        rec_we     = 1'b1;
        rec_waddr  = cand_q;
        rec_wdata  = '{st: rrts_pkg::THR_RUNNING, link: nxt_rec_q.link};
        cur_d      = cand_q;
        switched_d = 1'b1;
        done_d     = 1'b1;
        state_d    = rrts_pkg::FSM_IDLE;
      end

      rrts_pkg::FSM_CRE2: begin
        rec_we    = 1'b1;
        rec_waddr = '0;
        rec_wdata = '{st: old_rec_q.st, link: nfree_q[IW-1:0]};
        new_id_d  = nfree_q[IW-1:0];
        nfree_d   = nfree_q + CW'(1);
        done_d    = 1'b1;
        state_d   = rrts_pkg::FSM_IDLE;
      end

      default: begin
        state_d = rrts_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rrts_pkg::FSM_IDLE;
      cur_q     <= '0;
      nfree_q   <= CW'(1);
      tick_q    <= '0;
      cur_cnt_q <= '0;
      rec0_ok_q <= 1'b0;
      cnt0_ok_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      nfree_q   <= nfree_d;
      tick_q    <= tick_d;
      cur_cnt_q <= cur_cnt_d;
      done_q    <= done_d;
      if (rec_we && rec_waddr == '0) begin
        rec0_ok_q <= 1'b1;
      end
      if (cnt_we && cnt_waddr == '0) begin
        cnt0_ok_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    tgt_q      <= tgt_d;
    cand_q     <= cand_d;
    old_rec_q  <= old_rec_d;
    nxt_rec_q  <= nxt_rec_d;
    status_q   <= status_d;
    switched_q <= switched_d;
    new_id_q   <= new_id_d;
    if (rec_re) begin
      rec_raddr_q <= rec_raddr;
    end
    if (cnt_re) begin
      cnt_raddr_q <= cnt_raddr;
    end
  end

  assign busy_o         = (state_q != rrts_pkg::FSM_IDLE);
  assign done_o         = done_q;
  assign status_o       = status_q;
  assign current_id_o   = 4'(cur_q);
  assign switched_o     = switched_q;
  assign new_id_o       = 4'(new_id_q);
  assign switch_count_o = cur_cnt_q;
  assign tick_total_o   = tick_q;

  // The result beat only appears once the sequencer is back in idle.
  `RRTS_ASSERT_IMP(a_done_idle, clk_i, rst_ni, done_q, state_q == rrts_pkg::FSM_IDLE)
  // An accepted event always makes the sequencer busy on the next cycle.
  `RRTS_ASSERT_NXT(a_start_busy, clk_i, rst_ni, start_i && !busy_o, busy_o)
  // A reported switch really moved the current thread.
  `RRTS_ASSERT_IMP(a_switch_moves, clk_i, rst_ni, done_q && switched_q, cur_q != $past(cur_q))
  // The running thread is always one that has been created.
  `RRTS_ASSERT_IMP(a_cur_created, clk_i, rst_ni, 1'b1, {1'b0, cur_q} < nfree_q)

endmodule

`default_nettype wire

[rtl/core/rrts_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
